// ===== hdl/shaws_pkg.sv =====
// ----------------------------------------------------------------------------
// shaws_pkg
// Types, round constants and helper functions shared by the SHA-256 word
// stream hasher: queue entry format, sequencer states, hash primitives.
// ----------------------------------------------------------------------------
package shaws_pkg;

	// Words in one 512-bit block, rounds per compression
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS      = 64;

	// Fixed codes and limits used by the sequencer
	localparam logic [5:0]  ROUND_LAST  = 6'd63;
	localparam logic [3:0]  SLOT_LEN_HI = 4'd14;
	localparam logic [3:0]  SLOT_LEN_LO = 4'd15;
	localparam logic [3:0]  SLOT_LAST   = 4'd15;
	localparam logic [2:0]  EMIT_LAST   = 3'd7;
	localparam logic [31:0] PAD_WORD    = 32'h8000_0000;
	localparam logic [63:0] WORD_BITS   = 64'd32;

	// Initial hash value H0..H7
	localparam logic [31:0] INIT_HASH [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Round constants
	localparam logic [31:0] RND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Sequencer states of the back end
	typedef enum logic [2:0] {
		ST_ABSORB,
		ST_PAD,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} state_t;

	// One queued message word, already in SHA (big-endian) byte order
	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} q_entry_t;

	// Head of the queue as seen by the back end
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	function automatic logic [31:0] bswap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== hdl/shaws_msg_if.sv =====
// ----------------------------------------------------------------------------
// shaws_msg_if
// Message word channel: valid/ready handshake, one 32-bit word per beat.
// ----------------------------------------------------------------------------
interface shaws_msg_if;
	logic        valid;
	logic        ready;
	logic [31:0] msg_word;
	logic        msg_last;

	modport source (output valid, output msg_word, output msg_last, input ready);
	modport sink   (input valid, input msg_word, input msg_last, output ready);
endinterface

// ===== hdl/shaws_dig_if.sv =====
// ----------------------------------------------------------------------------
// shaws_dig_if
// Digest channel: valid/ready handshake, one 32-bit digest word per beat.
// ----------------------------------------------------------------------------
interface shaws_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        digest_last;

	modport source (output valid, output digest_word, output digest_last, input ready);
	modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

// ===== hdl/sha256_word_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// sha256_word_stream_hasher_core
// SHA-256 over a stream of 32-bit message words with built-in padding.
// ----------------------------------------------------------------------------
// Usage:
//   msg channel: one beat per 32-bit word, first message byte in bits 7:0;
//   msg_last flags the final word. Messages are whole words.
//   digest channel: eight beats per message, hash bytes packed little-endian,
//   index 0 first; digest_last is set on the eighth beat.
//   Per 512-bit block the engine loads the 16-word block window and then
//   compresses it (64 rounds plus the chaining add); the two do not overlap.
//   The round loop, one round per cycle over the shared block window, sets
//   the pace of a long message. After the last word, padding fills out the
//   window and adds one or two compressions; the first digest beat is
//   loaded into the output register in the emit state that follows the
//   final chaining add.
//   An input queue of QUEUE_DEPTH words takes beats while the engine is busy.
//   A stalled digest receiver holds the output register and stops the engine
//   until the eighth beat is loaded; the next message is then absorbed while
//   that beat waits.
//   Reset clears the queue and loads the initial hash; no clearing pass.
// ----------------------------------------------------------------------------
module sha256_word_stream_hasher_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	shaws_msg_if.sink     msg,
	shaws_dig_if.source   digest
);

	shaws_pkg::q_head_t head;
	logic               pop;

	shaws_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.pop    (pop),
		.head   (head)
	);

	shaws_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.digest (digest)
	);

endmodule

// ===== hdl/shaws_front.sv =====
// ----------------------------------------------------------------------------
// shaws_front
// Input side: takes message beats, swaps them into SHA byte order and
// holds them in a small queue that the back end drains.
// ----------------------------------------------------------------------------
module shaws_front #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	shaws_msg_if.sink           msg,
	input  logic                pop,
	output shaws_pkg::q_head_t  head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	shaws_pkg::q_entry_t ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                push;
	logic                do_pop;

	// Accept while there is room
	assign msg.ready = (count_q != CNT_FULL);
	assign push      = msg.valid && msg.ready;
	assign do_pop    = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.entry = ent_q[rd_ptr_q];

	// Store the swapped word
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q].word <= shaws_pkg::bswap32(msg.msg_word);
			ent_q[wr_ptr_q].last <= msg.msg_last;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/shaws_back.sv =====
// ----------------------------------------------------------------------------
// shaws_back
// Hash engine: fills the 16-word block window, pads after the last word,
// runs 64 compression rounds one per cycle and streams out the digest.
// ----------------------------------------------------------------------------
module shaws_back (
	input  logic               clk,
	input  logic               arst_n,
	input  shaws_pkg::q_head_t head,
	output logic               pop,
	shaws_dig_if.source        digest
);

	shaws_pkg::state_t state_q;
	shaws_pkg::state_t state_d;

	logic [31:0] win_q [16];
	logic [31:0] h_q   [8];
	logic [31:0] v_q   [8];
	logic [3:0]  fill_q;
	logic [5:0]  round_q;
	logic [63:0] total_q;
	logic        pad_q;
	logic        first_q;
	logic        len_ok_q;
	logic        done_q;
	logic [2:0]  emit_idx_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic        out_last_q;

	logic        put_en;
	logic [31:0] put_word;
	logic [31:0] pad_word;
	logic        full;
	logic        round_en;
	logic        final_en;
	logic        load;
	logic [31:0] sched_w;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	assign full = (fill_q == shaws_pkg::SLOT_LAST);

	// Padding word for the current slot
	always_comb begin
		if (first_q) begin
			pad_word = shaws_pkg::PAD_WORD;
		end else if (len_ok_q && fill_q == shaws_pkg::SLOT_LEN_HI) begin
			pad_word = total_q[63:32];
		end else if (len_ok_q && fill_q == shaws_pkg::SLOT_LEN_LO) begin
			pad_word = total_q[31:0];
		end else begin
			pad_word = '0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			shaws_pkg::ST_ABSORB: begin
				if (head.valid) begin
					if (full) begin
						state_d = shaws_pkg::ST_ROUND;
					end else if (head.entry.last) begin
						state_d = shaws_pkg::ST_PAD;
					end
				end
			end
			shaws_pkg::ST_PAD: begin
				if (full) begin
					state_d = shaws_pkg::ST_ROUND;
				end
			end
			shaws_pkg::ST_ROUND: begin
				if (round_q == shaws_pkg::ROUND_LAST) begin
					state_d = shaws_pkg::ST_FINAL;
				end
			end
			shaws_pkg::ST_FINAL: begin
				if (done_q) begin
					state_d = shaws_pkg::ST_EMIT;
				end else if (pad_q) begin
					state_d = shaws_pkg::ST_PAD;
				end else begin
					state_d = shaws_pkg::ST_ABSORB;
				end
			end
			shaws_pkg::ST_EMIT: begin
				if (load && emit_idx_q == shaws_pkg::EMIT_LAST) begin
					state_d = shaws_pkg::ST_ABSORB;
				end
			end
			default: begin
				state_d = shaws_pkg::ST_ABSORB;
			end
		endcase
	end

	// Control decode
	always_comb begin
		pop      = 1'b0;
		put_en   = 1'b0;
		put_word = pad_word;
		round_en = 1'b0;
		final_en = 1'b0;
		load     = 1'b0;
		case (state_q)
			shaws_pkg::ST_ABSORB: begin
				pop      = head.valid;
				put_en   = head.valid;
				put_word = head.entry.word;
			end
			shaws_pkg::ST_PAD: begin
				put_en = 1'b1;
			end
			shaws_pkg::ST_ROUND: begin
				round_en = 1'b1;
			end
			shaws_pkg::ST_FINAL: begin
				final_en = 1'b1;
			end
			shaws_pkg::ST_EMIT: begin
				load = !out_valid_q || digest.ready;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Round datapath
	assign sched_w = shaws_pkg::sml_sig1(win_q[14]) + win_q[9]
		+ shaws_pkg::sml_sig0(win_q[1]) + win_q[0];
	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + shaws_pkg::big_sig1(v_q[4]) + ch
		+ shaws_pkg::RND_K[round_q] + win_q[0];
	assign t2  = shaws_pkg::big_sig0(v_q[0]) + maj;

	// Block window: shift in message or pad words, or schedule words
	always_ff @(posedge clk) begin
		if (put_en || round_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= put_en ? put_word : sched_w;
		end
	end

	// Working variables a..h
	always_ff @(posedge clk) begin
		if (put_en && full) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (round_en) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	// Digest output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q <= shaws_pkg::bswap32(h_q[emit_idx_q]);
			out_last_q <= (emit_idx_q == shaws_pkg::EMIT_LAST);
		end
	end

	// Sequencer, chaining hash and message bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shaws_pkg::ST_ABSORB;
			fill_q      <= '0;
			round_q     <= '0;
			total_q     <= '0;
			pad_q       <= 1'b0;
			first_q     <= 1'b0;
			len_ok_q    <= 1'b0;
			done_q      <= 1'b0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= shaws_pkg::INIT_HASH[i];
			end
		end else begin
			state_q <= state_d;

			if (put_en) begin
				fill_q <= fill_q + 1'b1;
			end

			// Count message bits and start padding on the last word
			if (pop) begin
				total_q <= total_q + shaws_pkg::WORD_BITS;
				if (head.entry.last) begin
					pad_q    <= 1'b1;
					first_q  <= 1'b1;
					len_ok_q <= 1'b0;
					done_q   <= 1'b0;
				end
			end

			// Track where the padding and the length land
			if (state_q == shaws_pkg::ST_PAD) begin
				first_q <= 1'b0;
				if (full) begin
					done_q   <= len_ok_q && !first_q;
					len_ok_q <= 1'b1;
				end else if (first_q) begin
					len_ok_q <= (fill_q < shaws_pkg::SLOT_LEN_HI);
				end
			end

			if (put_en && full) begin
				round_q <= '0;
			end else if (round_en) begin
				round_q <= round_q + 1'b1;
			end

			// Fold the block result into the chaining hash
			if (final_en) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
				emit_idx_q <= '0;
			end

			// Drive the output register; reset for the next message after the eighth word
			if (load) begin
				out_valid_q <= 1'b1;
				emit_idx_q  <= emit_idx_q + 1'b1;
				if (emit_idx_q == shaws_pkg::EMIT_LAST) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= shaws_pkg::INIT_HASH[i];
					end
					total_q  <= '0;
					pad_q    <= 1'b0;
					first_q  <= 1'b0;
					len_ok_q <= 1'b0;
					done_q   <= 1'b0;
				end
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign digest.valid       = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.digest_last = out_last_q;

	// Checks
	a_round_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shaws_pkg::ST_ROUND && round_q == shaws_pkg::ROUND_LAST)
		|=> state_q == shaws_pkg::ST_FINAL)
		else $error("compression did not end after the last round");

	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shaws_pkg::ST_ROUND && $past(state_q) != shaws_pkg::ST_ROUND)
		|-> (round_q == '0 && fill_q == '0))
		else $error("compression started mid-block");

	a_emit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == shaws_pkg::ST_EMIT |-> (fill_q == '0 && pad_q && done_q && !first_q))
		else $error("digest emitted before the length block was compressed");

	a_msg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(load && emit_idx_q == shaws_pkg::EMIT_LAST)
		|=> (state_q == shaws_pkg::ST_ABSORB && total_q == '0
			&& h_q[0] == shaws_pkg::INIT_HASH[0] && out_last_q))
		else $error("state not returned to initial hash after digest");

endmodule
